// ----- rtl/lcsc_pkg.sv -----
`timescale 1ns / 1ps

package lcsc_pkg;

  localparam int SlotCountDef = 64;
  localparam int CoordW       = 32;
  localparam int KeyW         = 2 * CoordW;
  localparam int SlotIdxOutW  = 6;

  localparam int SlotWDef = (SlotCountDef > 1) ? $clog2(SlotCountDef) : 1;

  // scan record that walks the cell row, sized for the default slot count
  typedef struct packed {
    logic                valid;
    logic                found;
    logic [SlotWDef-1:0] hit_slot;
    logic [SlotWDef-1:0] hit_rank;
    logic                free_found;
    logic [SlotWDef-1:0] free_slot;
    logic [SlotWDef-1:0] victim_slot;
    logic [KeyW-1:0]     victim_key;
  } scan_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic                en;
    logic [SlotWDef-1:0] slot;
    logic                wr;
    logic                fresh;
    logic [SlotWDef-1:0] limit;
  } upd_t;

endpackage

// ----- rtl/lcsc_cell.sv -----
`timescale 1ns / 1ps

module lcsc_cell #(
  parameter int  SLOT_COUNT = lcsc_pkg::SlotCountDef,
  parameter int  IDX        = 0,
  parameter type scan_t     = lcsc_pkg::scan_t,
  parameter type upd_t      = lcsc_pkg::upd_t
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lcsc_pkg::KeyW-1:0] key_i,
  input  scan_t                     rec_i,
  input  upd_t                      upd_i,
  output scan_t                     rec_o
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SlotW-1:0] MyIdx   = SlotW'(IDX);
  localparam logic [SlotW-1:0] MaxRank = SlotW'(SLOT_COUNT - 1);

  logic [lcsc_pkg::KeyW-1:0] key_q, key_d;
  logic                      used_q, used_d;
  logic [SlotW-1:0]          rank_q, rank_d;
  scan_t                     rec_q, rec_d;
  logic                      match;

  assign match = used_q && (key_q == key_i);

  always_comb begin
    rec_d = rec_i;
    if (rec_i.valid) begin
      if (match && !rec_i.found) begin
        rec_d.found    = 1'b1;
        rec_d.hit_slot = MyIdx;
        rec_d.hit_rank = rank_q;
      end
      if (!used_q && !rec_i.free_found) begin
        rec_d.free_found = 1'b1;
        rec_d.free_slot  = MyIdx;
      end
      // with every slot used the ranks form a permutation, so one cell is oldest
      if (used_q && rank_q == MaxRank) begin
        rec_d.victim_slot = MyIdx;
        rec_d.victim_key  = key_q;
      end
    end
  end

  always_comb begin
    key_d  = key_q;
    used_d = used_q;
    rank_d = rank_q;
    if (upd_i.en) begin
      if (upd_i.slot == MyIdx) begin
        rank_d = '0;
        used_d = 1'b1;
        if (upd_i.wr) begin
          key_d = key_i;
        end
      end else if (used_q && (upd_i.fresh || rank_q < upd_i.limit)) begin
        rank_d = rank_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      rank_q <= '0;
      rec_q  <= '0;
    end else begin
      used_q <= used_d;
      rank_q <= rank_d;
      rec_q  <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign rec_o = rec_q;

endmodule

// ----- rtl/lru_chunk_slot_cache_core.sv -----
`timescale 1ns / 1ps

// channel   handshake               payload
// ------    ---------------------   ---------------------------------------------
// in        in_valid_i/in_ready_o   chunk_x_i, chunk_y_i
// out       out_valid_o/out_ready_i hit_o, slot_index_o, evicted_o,
//                                   evicted_x_o, evicted_y_o
//
// one request at a time: a scan record walks the row of SLOT_COUNT cells, one cell
// per cycle, then a single update is broadcast; in_ready_o rises again only once that
// update is made, so a new request is not taken until the last one is through.
// reset empties every slot; keys are not cleared and are never matched until written.
// the result sits in an output register; if it has not been taken when the next one
// is ready, the block holds the finished scan until the output frees up.

module lru_chunk_slot_cache_core #(
  parameter int SLOT_COUNT = lcsc_pkg::SlotCountDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [lcsc_pkg::CoordW-1:0]      chunk_x_i,
  input  logic signed [lcsc_pkg::CoordW-1:0]      chunk_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    hit_o,
  output logic        [lcsc_pkg::SlotIdxOutW-1:0] slot_index_o,
  output logic                                    evicted_o,
  output logic signed [lcsc_pkg::CoordW-1:0]      evicted_x_o,
  output logic signed [lcsc_pkg::CoordW-1:0]      evicted_y_o
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KeyW  = lcsc_pkg::KeyW;
  localparam int CW    = lcsc_pkg::CoordW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [SlotW-1:0] hit_slot;
    logic [SlotW-1:0] hit_rank;
    logic             free_found;
    logic [SlotW-1:0] free_slot;
    logic [SlotW-1:0] victim_slot;
    logic [KeyW-1:0]  victim_key;
  } scan_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic             wr;
    logic             fresh;
    logic [SlotW-1:0] limit;
  } upd_t;

  logic [1:0]      state_q, state_d;
  logic [KeyW-1:0] key_q;
  scan_t           head_q, head_d;
  scan_t           res_q;
  scan_t           chain [SLOT_COUNT];
  scan_t           tail;
  upd_t            upd;
  logic            in_acc;
  logic            finish;

  logic            out_valid_q;
  logic            hit_q;
  logic [SlotW-1:0] slot_q;
  logic            ev_q;
  logic [KeyW-1:0] ev_key_q;

  logic [SlotW-1:0] sel_slot;
  logic             sel_ev;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tail       = chain[SLOT_COUNT-1];
  assign finish     = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    head_d       = '0;
    head_d.valid = in_acc;
  end

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      if (g == 0) begin : g_head
        lcsc_cell #(
          .SLOT_COUNT(SLOT_COUNT),
          .IDX       (g),
          .scan_t    (scan_t),
          .upd_t     (upd_t)
        ) u_cell (
          .clk_i (clk_i),
          .rst_ni(rst_ni),
          .key_i (key_q),
          .rec_i (head_q),
          .upd_i (upd),
          .rec_o (chain[g])
        );
      end else begin : g_body
        lcsc_cell #(
          .SLOT_COUNT(SLOT_COUNT),
          .IDX       (g),
          .scan_t    (scan_t),
          .upd_t     (upd_t)
        ) u_cell (
          .clk_i (clk_i),
          .rst_ni(rst_ni),
          .key_i (key_q),
          .rec_i (chain[g-1]),
          .upd_i (upd),
          .rec_o (chain[g])
        );
      end
    end
  endgenerate

  // pick the slot: hit, else lowest free, else the oldest
  always_comb begin
    sel_ev = !res_q.found && !res_q.free_found;
    priority if (res_q.found) begin
      sel_slot = res_q.hit_slot;
    end else if (res_q.free_found) begin
      sel_slot = res_q.free_slot;
    end else begin
      sel_slot = res_q.victim_slot;
    end
  end

  always_comb begin
    upd.en    = finish;
    upd.slot  = sel_slot;
    upd.wr    = !res_q.found;
    upd.fresh = !res_q.found && res_q.free_found;
    upd.limit = res_q.found ? res_q.hit_rank : SlotW'(SLOT_COUNT - 1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StScan;
      StScan: if (tail.valid) state_d = StDone;
      StDone: if (finish) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= {chunk_x_i, chunk_y_i};
    end
    if (tail.valid) begin
      res_q <= tail;
    end
    if (finish) begin
      hit_q    <= res_q.found;
      slot_q   <= sel_slot;
      ev_q     <= sel_ev;
      ev_key_q <= sel_ev ? res_q.victim_key : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign slot_index_o = lcsc_pkg::SlotIdxOutW'(slot_q);
  assign evicted_o    = ev_q;
  assign evicted_x_o  = $signed(ev_key_q[KeyW-1:CW]);
  assign evicted_y_o  = $signed(ev_key_q[CW-1:0]);

endmodule
